@@ hw/rtl/ffca_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// First-fit chunk allocator package
// Status codes and request kinds shared by the allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_SIZE  = 3'd1,
        ST_NO_SPACE  = 3'd2,
        ST_NULL      = 3'd3,
        ST_OUTSIDE   = 3'd4,
        ST_NOT_START = 3'd5,
        ST_DOUBLE    = 3'd6
    } t_status;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam int HDR_BYTES = 4;

endpackage
`default_nettype wire

@@ hw/rtl/first_fit_chunk_allocator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// First-fit chunk allocator
// Header chain held in one synchronous memory; requests walk the chain.
// ----------------------------------------------------------------------------
// Timing: a request rejected on its fields strobes its result in the cycle after
// acceptance. An allocate visits each chunk through S_RD and S_CHK, and adds
// S_SPLIT when it splits; a free walks S_RD/S_CHK to the target, then walks the
// chain from entry 0 in S_MRD/S_MCHK, with S_NRD/S_NCHK and S_MWR per free run.
// One request at a time; busy is high from acceptance to strobe, bar field rejects.
// Reset: entry 0 is written as one free chunk over the arena.
module first_fit_chunk_allocator_top #(
    parameter int ARENA_BYTES = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_action,
    input  wire logic [15:0] i_request_size,
    input  wire logic        i_pointer_is_null,
    input  wire logic [15:0] i_free_offset,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic [15:0]      o_payload_offset
);

    localparam int TOTAL = ARENA_BYTES + ffca_pkg::HDR_BYTES;
    localparam int AW    = $clog2(TOTAL);
    localparam logic [17:0] TOTAL18 = 18'(TOTAL);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RD, S_CHK, S_SPLIT, S_MRD, S_MCHK, S_NRD, S_NCHK, S_MWR
    } t_state;

    t_state      r_state;
    logic [16:0] r_mem [TOTAL];
    logic [16:0] r_rdata;
    logic        r_action;
    logic [15:0] r_req;
    logic [17:0] r_target;
    logic [17:0] r_h;   // current header
    logic [17:0] r_s;   // accumulated size while merging
    logic [17:0] r_n;   // next header while merging

    // Memory port signals.
    logic        w_we;
    logic [AW-1:0] w_waddr;
    logic [16:0] w_wdata;
    logic [AW-1:0] w_raddr;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    logic [17:0] w_next;
    assign w_next = r_h + 18'(ffca_pkg::HDR_BYTES) + {2'b0, r_rdata[15:0]};

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_h[AW-1:0];
        w_wdata = '0;
        w_raddr = r_h[AW-1:0];
        case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = {1'b0, 16'(ARENA_BYTES)};
            end
            S_CHK: begin
                if (!r_action && !r_rdata[16] && r_rdata[15:0] >= r_req) begin
                    w_we    = 1'b1;
                    w_waddr = r_h[AW-1:0];
                    if ({2'b0, r_rdata[15:0]} >= {2'b0, r_req} + 18'd5) begin
                        w_wdata = {1'b1, r_req};
                    end else begin
                        w_wdata = {1'b1, r_rdata[15:0]};
                    end
                end else if (r_action && r_h == r_target && r_rdata[16]) begin
                    w_we    = 1'b1;
                    w_wdata = {1'b0, r_rdata[15:0]};
                end
            end
            S_SPLIT: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_h + 18'(ffca_pkg::HDR_BYTES) + {2'b0, r_req});
                w_wdata = {1'b0, 16'(r_s - {2'b0, r_req} - 18'(ffca_pkg::HDR_BYTES))};
            end
            S_NRD: w_raddr = r_n[AW-1:0];
            S_MWR: begin
                w_we    = 1'b1;
                w_wdata = {1'b0, r_s[15:0]};
            end
            default: ;
        endcase
    end

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_INIT: r_state <= S_IDLE;
                S_IDLE: begin
                    if (start) begin
                        r_action <= i_action;
                        r_req    <= i_request_size;
                        r_target <= {2'b0, i_free_offset} - 18'(ffca_pkg::HDR_BYTES);
                        r_h      <= '0;
                        o_payload_offset <= '0;
                        if (i_action == ffca_pkg::ACT_ALLOC) begin
                            if (i_request_size == 16'd0 ||
                                {2'b0, i_request_size} > 18'(ARENA_BYTES)) begin
                                o_valid  <= 1'b1;
                                o_status <= ffca_pkg::ST_BAD_SIZE;
                            end else begin
                                r_state <= S_RD;
                            end
                        end else if (i_pointer_is_null) begin
                            o_valid  <= 1'b1;
                            o_status <= ffca_pkg::ST_NULL;
                        end else if ({2'b0, i_free_offset} > TOTAL18) begin
                            o_valid  <= 1'b1;
                            o_status <= ffca_pkg::ST_OUTSIDE;
                        end else if (i_free_offset < 16'(ffca_pkg::HDR_BYTES)) begin
                            o_valid  <= 1'b1;
                            o_status <= ffca_pkg::ST_NOT_START;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    if (r_h >= TOTAL18) begin
                        o_valid  <= 1'b1;
                        o_status <= r_action ? ffca_pkg::ST_NOT_START
                                             : ffca_pkg::ST_NO_SPACE;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_s <= {2'b0, r_rdata[15:0]};
                    if (!r_action) begin
                        if (!r_rdata[16] && r_rdata[15:0] >= r_req) begin
                            o_payload_offset <= 16'(r_h + 18'(ffca_pkg::HDR_BYTES));
                            if ({2'b0, r_rdata[15:0]} >= {2'b0, r_req} + 18'd5) begin
                                r_state <= S_SPLIT;
                            end else begin
                                o_valid  <= 1'b1;
                                o_status <= ffca_pkg::ST_OK;
                                r_state  <= S_IDLE;
                            end
                        end else begin
                            r_h     <= w_next;
                            r_state <= S_RD;
                        end
                    end else if (r_h == r_target) begin
                        if (!r_rdata[16]) begin
                            o_valid  <= 1'b1;
                            o_status <= ffca_pkg::ST_DOUBLE;
                            r_state  <= S_IDLE;
                        end else begin
                            r_h     <= '0;
                            r_state <= S_MRD;
                        end
                    end else begin
                        r_h     <= w_next;
                        r_state <= S_RD;
                    end
                end
                S_SPLIT: begin
                    o_valid  <= 1'b1;
                    o_status <= ffca_pkg::ST_OK;
                    r_state  <= S_IDLE;
                end
                S_MRD: begin
                    if (r_h >= TOTAL18) begin
                        o_valid  <= 1'b1;
                        o_status <= ffca_pkg::ST_OK;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_MCHK;
                    end
                end
                S_MCHK: begin
                    r_s <= {2'b0, r_rdata[15:0]};
                    if (!r_rdata[16]) begin
                        r_n     <= w_next;
                        r_state <= S_NRD;
                    end else begin
                        r_h     <= w_next;
                        r_state <= S_MRD;
                    end
                end
                S_NRD: begin
                    if (r_n >= TOTAL18) begin
                        r_state <= S_MWR;
                    end else begin
                        r_state <= S_NCHK;
                    end
                end
                S_NCHK: begin
                    if (!r_rdata[16]) begin
                        r_s     <= r_s + 18'(ffca_pkg::HDR_BYTES) + {2'b0, r_rdata[15:0]};
                        r_n     <= r_n + 18'(ffca_pkg::HDR_BYTES) + {2'b0, r_rdata[15:0]};
                        r_state <= S_NRD;
                    end else begin
                        r_state <= S_MWR;
                    end
                end
                S_MWR: begin
                    // The merged chunk ends at the next used header or the arena end.
                    r_h     <= r_n;
                    r_state <= S_MRD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy) || $past(start))
        else $error("result without request");
    a_ok_alloc_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ffca_pkg::ST_OK && !r_action) |-> o_payload_offset >= 16'd4)
        else $error("granted offset below header");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ffca_pkg::ST_OK) |-> o_payload_offset == 16'd0)
        else $error("offset on failed request");
`endif

endmodule
`default_nettype wire
